@@ src/rci_pkg.sv @@
// Shared types, constants and fixed-point helpers of the ray/cylinder test.
package rci_pkg;

  localparam int FRAC_BITS    = 16;
  localparam int MIN_DISTANCE = 16;
  localparam int SQ_STEPS     = 32;
  localparam int DIV_STEPS    = 33;
  localparam int NUM_REGS     = 8;

  typedef enum logic [2:0] {
    REG_CENTER_X = 3'd0,
    REG_CENTER_Y = 3'd1,
    REG_CENTER_Z = 3'd2,
    REG_AXIS_X   = 3'd3,
    REG_AXIS_Y   = 3'd4,
    REG_AXIS_Z   = 3'd5,
    REG_RADIUS   = 3'd6,
    REG_HEIGHT   = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic [2:0][31:0] cen;
    logic [2:0][17:0] ax;
    logic [30:0]      rad;
    logic [30:0]      ht;
  } cfg_t;

  // Ray payload that rides along the pipeline
  typedef struct packed {
    logic [2:0][31:0] org;
    logic [2:0][17:0] dir;
    logic [2:0][31:0] oc;
    logic [31:0]      h;
    logic [31:0]      a;
    logic             ok;
  } ray_t;

  typedef struct packed {
    logic             hit;
    logic [30:0]      distance;
    logic [2:0][31:0] pt;
    logic [2:0][31:0] nrm;
  } res_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
    if (x > 66'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (x < -66'sd2147483648) begin
      return 32'sh80000000;
    end
    return 32'(x);
  endfunction

  // Product of two fixed-point values, rounded half up to FRAC_BITS
  function automatic logic signed [47:0] mulr(input logic signed [31:0] x,
                                              input logic signed [31:0] y);
    logic signed [63:0] p;
    p = x * y + (64'sd1 <<< (FRAC_BITS - 1));
    return 48'(p >>> FRAC_BITS);
  endfunction

endpackage

@@ src/rci_front.sv @@
// Projection off the axis, quadratic coefficients and discriminant.
module rci_front import rci_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  cfg_t             cfg_i,
  input  logic             valid_i,
  input  logic [2:0][31:0] org_i,
  input  logic [2:0][17:0] dir_i,
  output logic             valid_o,
  output ray_t             ray_o,
  output logic [63:0]      disc_o
);

  logic [7:0] v_q, v_d;

  ray_t r1_q, r2_q, r3_q, r4_q, r5_q, r6_q, r7_q, r8_q;
  ray_t r1_d, r6_d, r7_d, r8_d;
  logic [2:0][19:0] dnp_q, dnp_d;
  logic [21:0]      dn_q, dn_d;
  logic [2:0][33:0] ocnp_q, ocnp_d;
  logic [31:0]      ocn_q, ocn_d;
  logic [2:0][31:0] u3_q, u3_d, u4_q, pv_q, pv_d;
  logic [2:0][47:0] uu_q, uu_d, uv_q, uv_d, vv_q, vv_d;
  logic [47:0]      rr_q, rr_d;
  logic [31:0]      c_q, c_d;
  logic [63:0]      hh_q, hh_d, ac_q, ac_d;
  logic [63:0]      disc_q;
  logic signed [64:0] disc_w;

  always_comb begin
    v_d = {v_q[6:0], valid_i};
    r1_d = '0;
    r1_d.org = org_i;
    r1_d.dir = dir_i;
    for (int i = 0; i < 3; i++) begin
      r1_d.oc[i] = sat32(66'($signed(cfg_i.cen[i])) - 66'($signed(org_i[i])));
      dnp_d[i] = 20'(mulr(32'($signed(dir_i[i])), 32'($signed(cfg_i.ax[i]))));
    end
    // stage 2
    dn_d = 22'($signed(dnp_q[0])) + 22'($signed(dnp_q[1])) + 22'($signed(dnp_q[2]));
    for (int i = 0; i < 3; i++) begin
      ocnp_d[i] = 34'(mulr($signed(r1_q.oc[i]), 32'($signed(cfg_i.ax[i]))));
    end
    // stage 3
    ocn_d = sat32(66'($signed(ocnp_q[0])) + 66'($signed(ocnp_q[1]))
                  + 66'($signed(ocnp_q[2])));
    for (int i = 0; i < 3; i++) begin
      u3_d[i] = sat32(66'($signed(r2_q.dir[i]))
                - 66'(mulr(32'($signed(dn_q)), 32'($signed(cfg_i.ax[i])))));
    end
    // stage 4
    for (int i = 0; i < 3; i++) begin
      pv_d[i] = sat32(66'($signed(r3_q.oc[i]))
                - 66'(mulr($signed(ocn_q), 32'($signed(cfg_i.ax[i])))));
    end
    // stage 5
    for (int i = 0; i < 3; i++) begin
      uu_d[i] = mulr($signed(u4_q[i]), $signed(u4_q[i]));
      uv_d[i] = mulr($signed(u4_q[i]), $signed(pv_q[i]));
      vv_d[i] = mulr($signed(pv_q[i]), $signed(pv_q[i]));
    end
    rr_d = mulr(32'({1'b0, cfg_i.rad}), 32'({1'b0, cfg_i.rad}));
    // stage 6
    r6_d = r5_q;
    r6_d.a = sat32(66'($signed(uu_q[0])) + 66'($signed(uu_q[1])) + 66'($signed(uu_q[2])));
    r6_d.h = sat32(66'($signed(uv_q[0])) + 66'($signed(uv_q[1])) + 66'($signed(uv_q[2])));
    c_d = sat32(66'($signed(vv_q[0])) + 66'($signed(vv_q[1])) + 66'($signed(vv_q[2]))
                - 66'($signed(rr_q)));
    // stage 7
    r7_d = r6_q;
    hh_d = $signed(r6_q.h) * $signed(r6_q.h);
    ac_d = $signed(r6_q.a) * $signed(c_q);
    // stage 8
    disc_w = 65'($signed(hh_q)) - 65'($signed(ac_q));
    r8_d = r7_q;
    r8_d.ok = ($signed(r7_q.a) > 32'sd0) && !disc_w[64];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r1_q   <= r1_d;
      dnp_q  <= dnp_d;
      r2_q   <= r1_q;
      dn_q   <= dn_d;
      ocnp_q <= ocnp_d;
      r3_q   <= r2_q;
      ocn_q  <= ocn_d;
      u3_q   <= u3_d;
      r4_q   <= r3_q;
      u4_q   <= u3_q;
      pv_q   <= pv_d;
      r5_q   <= r4_q;
      uu_q   <= uu_d;
      uv_q   <= uv_d;
      vv_q   <= vv_d;
      rr_q   <= rr_d;
      r6_q   <= r6_d;
      c_q    <= c_d;
      r7_q   <= r7_d;
      hh_q   <= hh_d;
      ac_q   <= ac_d;
      r8_q   <= r8_d;
      disc_q <= disc_w[63:0];
    end
  end

  assign valid_o = v_q[7];
  assign ray_o   = r8_q;
  assign disc_o  = disc_q;

endmodule

@@ src/rci_sqrt.sv @@
// Pipelined integer square root, one result bit per stage, rounded to nearest.
module rci_sqrt import rci_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        valid_i,
  input  ray_t        ray_i,
  input  logic [63:0] x_i,
  output logic        valid_o,
  output ray_t        ray_o,
  output logic [32:0] s_o
);

  logic [SQ_STEPS-1:0] v_q;
  logic [63:0] x_q [SQ_STEPS];
  logic [63:0] r_q [SQ_STEPS];
  ray_t        ray_q [SQ_STEPS];

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_step
    localparam logic [63:0] Bit = 64'd1 << (62 - 2 * k);
    logic [63:0] x_in, r_in, trial, x_d, r_d;
    logic        v_in;
    ray_t        ray_in;

    if (k == 0) begin : g_first
      assign x_in   = x_i;
      assign r_in   = '0;
      assign v_in   = valid_i;
      assign ray_in = ray_i;
    end else begin : g_next
      assign x_in   = x_q[k-1];
      assign r_in   = r_q[k-1];
      assign v_in   = v_q[k-1];
      assign ray_in = ray_q[k-1];
    end

    always_comb begin
      trial = r_in + Bit;
      if (x_in >= trial) begin
        x_d = x_in - trial;
        r_d = (r_in >> 1) + Bit;
      end else begin
        x_d = x_in;
        r_d = r_in >> 1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[k]   <= x_d;
        r_q[k]   <= r_d;
        ray_q[k] <= ray_in;
      end
    end
  end

  logic        vo_q;
  ray_t        rayo_q;
  logic [32:0] s_q, s_d;

  // round up when the remainder exceeds the floor root
  assign s_d = 33'(r_q[SQ_STEPS-1]) + 33'(x_q[SQ_STEPS-1] > r_q[SQ_STEPS-1]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else if (en_i) begin
      vo_q <= v_q[SQ_STEPS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s_q    <= s_d;
      rayo_q <= ray_q[SQ_STEPS-1];
    end
  end

  assign valid_o = vo_q;
  assign ray_o   = rayo_q;
  assign s_o     = s_q;

endmodule

@@ src/rci_div.sv @@
// Two pipelined restoring dividers for the near and far roots.
module rci_div import rci_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  ray_t             ray_i,
  input  logic [32:0]      s_i,
  output logic             valid_o,
  output ray_t             ray_o,
  output logic [1:0][31:0] t_o
);

  // prep stage: magnitude, rounding offset, overflow check
  logic             pv_q;
  ray_t             pray_q;
  logic [1:0][50:0] pd_q, pd_d;
  logic [1:0]       pneg_q, pneg_d, pbig_q, pbig_d;

  always_comb begin
    logic signed [34:0] num;
    logic [33:0]        mag;
    for (int r = 0; r < 2; r++) begin
      if (r == 0) begin
        num = 35'($signed(ray_i.h)) - 35'($signed({1'b0, s_i}));
      end else begin
        num = 35'($signed(ray_i.h)) + 35'($signed({1'b0, s_i}));
      end
      mag = num[34] ? 34'(-num) : 34'(num);
      pneg_d[r] = num[34];
      pd_d[r] = (51'(mag) << FRAC_BITS) + 51'(ray_i.a[31:1]);
      pbig_d[r] = 66'(pd_d[r]) >= (66'(ray_i.a) << DIV_STEPS);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= 1'b0;
    end else if (en_i) begin
      pv_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pray_q <= ray_i;
      pd_q   <= pd_d;
      pneg_q <= pneg_d;
      pbig_q <= pbig_d;
    end
  end

  logic [DIV_STEPS-1:0] v_q;
  ray_t             ray_q [DIV_STEPS];
  logic [1:0][50:0] d_q   [DIV_STEPS];
  logic [1:0][31:0] rem_q [DIV_STEPS];
  logic [1:0][32:0] q_q   [DIV_STEPS];
  logic [1:0]       neg_q [DIV_STEPS];
  logic [1:0]       big_q [DIV_STEPS];

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    logic             v_in;
    ray_t             ray_in;
    logic [1:0][50:0] d_in;
    logic [1:0][31:0] rem_in, rem_d;
    logic [1:0][32:0] q_in, q_d;
    logic [1:0]       neg_in, big_in;

    if (k == 0) begin : g_first
      assign v_in   = pv_q;
      assign ray_in = pray_q;
      assign d_in   = pd_q;
      assign neg_in = pneg_q;
      assign big_in = pbig_q;
      assign q_in   = '0;
      for (genvar r = 0; r < 2; r++) begin : g_lane
        assign rem_in[r] = 32'(pd_q[r] >> DIV_STEPS);
      end
    end else begin : g_next
      assign v_in   = v_q[k-1];
      assign ray_in = ray_q[k-1];
      assign d_in   = d_q[k-1];
      assign neg_in = neg_q[k-1];
      assign big_in = big_q[k-1];
      assign q_in   = q_q[k-1];
      assign rem_in = rem_q[k-1];
    end

    always_comb begin
      logic [32:0] trial;
      for (int r = 0; r < 2; r++) begin
        trial = {rem_in[r], d_in[r][DIV_STEPS-1-k]};
        if (trial >= 33'(ray_in.a)) begin
          rem_d[r] = 32'(trial - 33'(ray_in.a));
          q_d[r]   = {q_in[r][31:0], 1'b1};
        end else begin
          rem_d[r] = trial[31:0];
          q_d[r]   = {q_in[r][31:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        ray_q[k] <= ray_in;
        d_q[k]   <= d_in;
        rem_q[k] <= rem_d;
        q_q[k]   <= q_d;
        neg_q[k] <= neg_in;
        big_q[k] <= big_in;
      end
    end
  end

  // sign and saturate
  logic             vo_q;
  ray_t             rayo_q;
  logic [1:0][31:0] t_q, t_d;

  always_comb begin
    logic [32:0] q;
    for (int r = 0; r < 2; r++) begin
      q = q_q[DIV_STEPS-1][r];
      if (!neg_q[DIV_STEPS-1][r]) begin
        if (big_q[DIV_STEPS-1][r] || q > 33'h07fffffff) begin
          t_d[r] = 32'h7fffffff;
        end else begin
          t_d[r] = q[31:0];
        end
      end else begin
        if (big_q[DIV_STEPS-1][r] || q > 33'h080000000) begin
          t_d[r] = 32'h80000000;
        end else begin
          t_d[r] = 32'(-q);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else if (en_i) begin
      vo_q <= v_q[DIV_STEPS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rayo_q <= ray_q[DIV_STEPS-1];
      t_q    <= t_d;
    end
  end

  assign valid_o = vo_q;
  assign ray_o   = rayo_q;
  assign t_o     = t_q;

endmodule

@@ src/rci_back.sv @@
// Hit point, height check and normal for both roots, then root selection.
module rci_back import rci_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  cfg_t             cfg_i,
  input  logic             valid_i,
  input  ray_t             ray_i,
  input  logic [1:0][31:0] t_i,
  output logic             valid_o,
  output res_t             res_o
);

  logic [3:0] v_q;
  ray_t r1_q, r2_q, r3_q;
  logic [1:0][31:0] t1_q, t2_q, t3_q;
  logic [1:0]       gt1_q, gt1_d, gt2_q, gt3_q, okh_q, okh_d;
  logic [1:0][2:0][33:0] p1_q, p1_d, p2_q, p3_q, wa_q, wa_d, hax_q, hax_d;
  logic [1:0][2:0][34:0] w2_q, w2_d, w3_q;
  res_t res_q, res_d;

  always_comb begin
    logic signed [31:0] ws, hh;
    logic [1:0]         hit;
    logic [1:0][2:0][31:0] pt, nrm;
    for (int r = 0; r < 2; r++) begin
      gt1_d[r] = $signed(t_i[r]) > 32'(MIN_DISTANCE);
      for (int i = 0; i < 3; i++) begin
        p1_d[r][i] = 34'(mulr($signed(t_i[r]), 32'($signed(ray_i.dir[i]))));
      end
      // stage 2
      for (int i = 0; i < 3; i++) begin
        w2_d[r][i] = 35'($signed(p1_q[r][i])) - 35'($signed(r1_q.oc[i]));
        ws = sat32(66'($signed(w2_d[r][i])));
        wa_d[r][i] = 34'(mulr(ws, 32'($signed(cfg_i.ax[i]))));
      end
      // stage 3
      hh = sat32(66'($signed(wa_q[r][0])) + 66'($signed(wa_q[r][1]))
                 + 66'($signed(wa_q[r][2])));
      okh_d[r] = !hh[31] && (hh[30:0] <= cfg_i.ht);
      for (int i = 0; i < 3; i++) begin
        hax_d[r][i] = 34'(mulr(hh, 32'($signed(cfg_i.ax[i]))));
      end
      // stage 4
      hit[r] = r3_q.ok && gt3_q[r] && okh_q[r];
      for (int i = 0; i < 3; i++) begin
        pt[r][i]  = sat32(66'($signed(r3_q.org[i])) + 66'($signed(p3_q[r][i])));
        nrm[r][i] = sat32(66'($signed(w3_q[r][i])) - 66'($signed(hax_q[r][i])));
      end
    end
    // take the near root first
    res_d = '0;
    if (hit[0]) begin
      res_d.hit      = 1'b1;
      res_d.distance = t3_q[0][30:0];
      res_d.pt       = pt[0];
      res_d.nrm      = nrm[0];
    end else if (hit[1]) begin
      res_d.hit      = 1'b1;
      res_d.distance = t3_q[1][30:0];
      res_d.pt       = pt[1];
      res_d.nrm      = nrm[1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r1_q  <= ray_i;
      t1_q  <= t_i;
      gt1_q <= gt1_d;
      p1_q  <= p1_d;
      r2_q  <= r1_q;
      t2_q  <= t1_q;
      gt2_q <= gt1_q;
      p2_q  <= p1_q;
      w2_q  <= w2_d;
      wa_q  <= wa_d;
      r3_q  <= r2_q;
      t3_q  <= t2_q;
      gt3_q <= gt2_q;
      p3_q  <= p2_q;
      w3_q  <= w2_q;
      okh_q <= okh_d;
      hax_q <= hax_d;
      res_q <= res_d;
    end
  end

  assign valid_o = v_q[3];
  assign res_o   = res_q;

endmodule

@@ src/ray_cylinder_intersect.sv @@
// Ray against open finite cylinder: config registers, pipeline and output skid.
//
//   channel | direction | handshake                  | payload
//   --------+-----------+----------------------------+-----------------------------
//   in      | request   | in_valid_i / in_stall_o    | origin_*_i, dir_*_i
//   out     | result    | out_valid_o / out_stall_i  | hit_o, distance_o, point_*_o,
//           |           |                            | surf_normal_*_o
//   cfg     | write     | cfg_we_i                   | cfg_idx_i, cfg_data_i
//
// One request per cycle while in_stall_o is low; the path runs through the projection and
// discriminant, the square root, the two dividers, the hit test and the output register.
// Reset clears all valid bits and loads the register reset values.
// A stalled output parks one result in a skid register; the pipeline then holds.
module ray_cylinder_intersect import rci_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [31:0] origin_x_i,
  input  logic signed [31:0] origin_y_i,
  input  logic signed [31:0] origin_z_i,
  input  logic signed [17:0] dir_x_i,
  input  logic signed [17:0] dir_y_i,
  input  logic signed [17:0] dir_z_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               hit_o,
  output logic [30:0]        distance_o,
  output logic signed [31:0] point_x_o,
  output logic signed [31:0] point_y_o,
  output logic signed [31:0] point_z_o,
  output logic signed [31:0] surf_normal_x_o,
  output logic signed [31:0] surf_normal_y_o,
  output logic signed [31:0] surf_normal_z_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cen <= '0;
      cfg_q.ax  <= {18'sd65536, 18'sd0, 18'sd0};
      cfg_q.rad <= 31'd65536;
      cfg_q.ht  <= 31'd65536;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_CENTER_X: cfg_q.cen[0] <= cfg_data_i;
        REG_CENTER_Y: cfg_q.cen[1] <= cfg_data_i;
        REG_CENTER_Z: cfg_q.cen[2] <= cfg_data_i;
        REG_AXIS_X:   cfg_q.ax[0]  <= cfg_data_i[17:0];
        REG_AXIS_Y:   cfg_q.ax[1]  <= cfg_data_i[17:0];
        REG_AXIS_Z:   cfg_q.ax[2]  <= cfg_data_i[17:0];
        REG_RADIUS:   cfg_q.rad    <= cfg_data_i[30:0];
        REG_HEIGHT:   cfg_q.ht     <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  logic             en;
  logic             fr_valid, sq_valid, dv_valid, bk_valid;
  ray_t             fr_ray, sq_ray, dv_ray;
  logic [63:0]      fr_disc;
  logic [32:0]      sq_s;
  logic [1:0][31:0] dv_t;
  res_t             bk_res;

  rci_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .cfg_i   (cfg_q),
    .valid_i (in_valid_i),
    .org_i   ({origin_z_i, origin_y_i, origin_x_i}),
    .dir_i   ({dir_z_i, dir_y_i, dir_x_i}),
    .valid_o (fr_valid),
    .ray_o   (fr_ray),
    .disc_o  (fr_disc)
  );

  rci_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fr_valid),
    .ray_i   (fr_ray),
    .x_i     (fr_disc),
    .valid_o (sq_valid),
    .ray_o   (sq_ray),
    .s_o     (sq_s)
  );

  rci_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sq_valid),
    .ray_i   (sq_ray),
    .s_i     (sq_s),
    .valid_o (dv_valid),
    .ray_o   (dv_ray),
    .t_o     (dv_t)
  );

  rci_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .cfg_i   (cfg_q),
    .valid_i (dv_valid),
    .ray_i   (dv_ray),
    .t_i     (dv_t),
    .valid_o (bk_valid),
    .res_o   (bk_res)
  );

  // output register plus skid
  logic out_valid_q, out_valid_d, skid_valid_q, skid_valid_d;
  logic pop, load_out, load_skid;
  res_t out_q, out_d, skid_q;

  assign en        = !skid_valid_q;
  assign in_stall_o = !en;
  assign pop       = out_valid_q && !out_stall_i;
  assign load_out  = skid_valid_q ? pop : (!out_valid_q || pop);
  assign load_skid = !skid_valid_q && out_valid_q && !pop && bk_valid;
  assign out_d     = skid_valid_q ? skid_q : bk_res;

  always_comb begin
    if (skid_valid_q) begin
      out_valid_d  = 1'b1;
      skid_valid_d = !pop;
    end else begin
      out_valid_d  = load_out ? bk_valid : out_valid_q;
      skid_valid_d = load_skid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_q <= out_d;
    end
    if (load_skid) begin
      skid_q <= bk_res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign hit_o           = out_q.hit;
  assign distance_o      = out_q.distance;
  assign point_x_o       = out_q.pt[0];
  assign point_y_o       = out_q.pt[1];
  assign point_z_o       = out_q.pt[2];
  assign surf_normal_x_o = out_q.nrm[0];
  assign surf_normal_y_o = out_q.nrm[1];
  assign surf_normal_z_o = out_q.nrm[2];

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid holds a result while the output register is empty");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.hit) |-> (out_q.distance == '0 && out_q.pt == '0
                                     && out_q.nrm == '0))
    else $error("miss result carries nonzero fields");

  a_hit_far: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.hit) |-> (out_q.distance > 31'(MIN_DISTANCE)))
    else $error("hit at a distance below the minimum");

  a_skid_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_valid_q && pop) |=> (out_valid_q && !skid_valid_q))
    else $error("skid result lost on drain");
`endif

endmodule

@@ tb/ray_cylinder_checker.sv @@
// Checker for the ray/cylinder test: tracks the registers, predicts each result, compares.
module ray_cylinder_checker import rci_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic signed [31:0] origin_x_i,
  input  logic signed [31:0] origin_y_i,
  input  logic signed [31:0] origin_z_i,
  input  logic signed [17:0] dir_x_i,
  input  logic signed [17:0] dir_y_i,
  input  logic signed [17:0] dir_z_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic               hit_i,
  input  logic [30:0]        distance_i,
  input  logic signed [31:0] point_x_i,
  input  logic signed [31:0] point_y_i,
  input  logic signed [31:0] point_z_i,
  input  logic signed [31:0] surf_normal_x_i,
  input  logic signed [31:0] surf_normal_y_i,
  input  logic signed [31:0] surf_normal_z_i,
  output int                 fail_count_o,
  output int                 pending_o
);

  typedef logic signed [127:0] wide_t;

  typedef struct {
    logic              hit;
    logic [30:0]       distance;
    logic signed [31:0] pt [3];
    logic signed [31:0] nrm [3];
  } hit_rec_t;

  wide_t    cen [3];
  wide_t    ax [3];
  wide_t    rad, ht;
  hit_rec_t hit_q [$];

  function automatic wide_t clamp32(wide_t x);
    if (x > 128'sd2147483647) return 128'sd2147483647;
    if (x < -128'sd2147483648) return -128'sd2147483648;
    return x;
  endfunction

  function automatic wide_t fxmul(wide_t x, wide_t y);
    return (x * y + (128'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
  endfunction

  function automatic wide_t fxdot(wide_t x [3], wide_t y [3]);
    return fxmul(x[0], y[0]) + fxmul(x[1], y[1]) + fxmul(x[2], y[2]);
  endfunction

  function automatic wide_t isqrt_round(wide_t x);
    wide_t r, b;
    r = 0;
    b = 128'sd1 <<< 124;
    while (b > x) b = b >>> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >>> 1) + b;
      end else begin
        r = r >>> 1;
      end
      b = b >>> 2;
    end
    if (x > r) r = r + 1;
    return r;
  endfunction

  function automatic wide_t root_quot(wide_t num, wide_t a);
    wide_t mag, q;
    mag = (num < 0) ? -num : num;
    q = ((mag <<< FRAC_BITS) + a / 2) / a;
    if (num >= 0) return (q > 128'sd2147483647) ? 128'sd2147483647 : q;
    return (q > 128'sd2147483648) ? -128'sd2147483648 : -q;
  endfunction

  // Test one root; fill point and normal when it lands on the side wall
  function automatic logic side_hit(wide_t t, wide_t org [3], wide_t dir [3], wide_t oc [3],
                                    output wide_t pt [3], output wide_t nrm [3]);
    wide_t p [3];
    wide_t w [3];
    wide_t ws [3];
    wide_t hh;
    for (int i = 0; i < 3; i++) begin
      pt[i] = 0;
      nrm[i] = 0;
    end
    if (t <= MIN_DISTANCE) return 1'b0;
    for (int i = 0; i < 3; i++) begin
      p[i] = fxmul(t, dir[i]);
      w[i] = p[i] - oc[i];
      ws[i] = clamp32(w[i]);
    end
    hh = clamp32(fxdot(ws, ax));
    if (hh < 0 || hh > ht) return 1'b0;
    for (int i = 0; i < 3; i++) begin
      pt[i] = clamp32(org[i] + p[i]);
      nrm[i] = clamp32(w[i] - fxmul(hh, ax[i]));
    end
    return 1'b1;
  endfunction

  function automatic hit_rec_t predict_hit(wide_t org [3], wide_t dir [3]);
    hit_rec_t r;
    wide_t oc [3];
    wide_t u [3];
    wide_t v [3];
    wide_t pt [3];
    wide_t nrm [3];
    wide_t dn, ocn, a, h, c, disc, s, t;
    logic hit;
    hit = 1'b0;
    t = 0;
    for (int i = 0; i < 3; i++) begin
      oc[i] = clamp32(cen[i] - org[i]);
      pt[i] = 0;
      nrm[i] = 0;
    end
    dn = clamp32(fxdot(dir, ax));
    ocn = clamp32(fxdot(oc, ax));
    for (int i = 0; i < 3; i++) begin
      u[i] = clamp32(dir[i] - fxmul(dn, ax[i]));
      v[i] = clamp32(oc[i] - fxmul(ocn, ax[i]));
    end
    a = clamp32(fxdot(u, u));
    h = clamp32(fxdot(u, v));
    c = clamp32(fxdot(v, v) - fxmul(rad, rad));
    if (a > 0) begin
      disc = h * h - a * c;
      if (disc >= 0) begin
        s = isqrt_round(disc);
        t = root_quot(h - s, a);
        hit = side_hit(t, org, dir, oc, pt, nrm);
        if (!hit) begin
          t = root_quot(h + s, a);
          hit = side_hit(t, org, dir, oc, pt, nrm);
        end
      end
    end
    r.hit = hit;
    r.distance = hit ? t[30:0] : '0;
    for (int i = 0; i < 3; i++) begin
      r.pt[i] = hit ? pt[i][31:0] : '0;
      r.nrm[i] = hit ? nrm[i][31:0] : '0;
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    wide_t org [3];
    wide_t dir [3];
    hit_rec_t e;
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) cen[i] = 0;
      ax[0] = 0;
      ax[1] = 0;
      ax[2] = 65536;
      rad = 65536;
      ht = 65536;
      fail_count_o = 0;
      pending_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (reg_idx_e'(cfg_idx_i))
          REG_CENTER_X: cen[0] = $signed(cfg_data_i);
          REG_CENTER_Y: cen[1] = $signed(cfg_data_i);
          REG_CENTER_Z: cen[2] = $signed(cfg_data_i);
          REG_AXIS_X:   ax[0] = $signed(cfg_data_i[17:0]);
          REG_AXIS_Y:   ax[1] = $signed(cfg_data_i[17:0]);
          REG_AXIS_Z:   ax[2] = $signed(cfg_data_i[17:0]);
          REG_RADIUS:   rad = {97'd0, cfg_data_i[30:0]};
          REG_HEIGHT:   ht = {97'd0, cfg_data_i[30:0]};
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        org[0] = origin_x_i;
        org[1] = origin_y_i;
        org[2] = origin_z_i;
        dir[0] = dir_x_i;
        dir[1] = dir_y_i;
        dir[2] = dir_z_i;
        hit_q.push_back(predict_hit(org, dir));
      end
      if (out_valid_i && !out_stall_i) begin
        if (hit_q.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10) $display("result with no request outstanding");
        end else begin
          e = hit_q.pop_front();
          if (hit_i !== e.hit || distance_i !== e.distance ||
              point_x_i !== e.pt[0] || point_y_i !== e.pt[1] || point_z_i !== e.pt[2] ||
              surf_normal_x_i !== e.nrm[0] || surf_normal_y_i !== e.nrm[1] ||
              surf_normal_z_i !== e.nrm[2]) begin
            fail_count_o++;
            if (fail_count_o <= 10) begin
              $display("mismatch: exp hit=%0d t=%0d p=(%0d,%0d,%0d) n=(%0d,%0d,%0d)",
                       e.hit, e.distance, e.pt[0], e.pt[1], e.pt[2],
                       e.nrm[0], e.nrm[1], e.nrm[2]);
              $display("          got hit=%0d t=%0d p=(%0d,%0d,%0d) n=(%0d,%0d,%0d)",
                       hit_i, distance_i, point_x_i, point_y_i, point_z_i,
                       surf_normal_x_i, surf_normal_y_i, surf_normal_z_i);
            end
          end
        end
      end
      pending_o = hit_q.size();
    end
  end

endmodule

@@ tb/tb.sv @@
// Testbench top for the ray/cylinder test: stimulus, flow control, watchdog and verdict.
module tb;
  import rci_pkg::*;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [2:0]         cfg_idx_i = '0;
  logic [31:0]        cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic signed [31:0] origin_x_i = '0, origin_y_i = '0, origin_z_i = '0;
  logic signed [17:0] dir_x_i = '0, dir_y_i = '0, dir_z_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic               hit_o;
  logic [30:0]        distance_o;
  logic signed [31:0] point_x_o, point_y_o, point_z_o;
  logic signed [31:0] surf_normal_x_o, surf_normal_y_o, surf_normal_z_o;
  int                 fail_count, pending;
  logic               calm = 1'b0;
  logic               hold_req = 1'b0;
  int                 quiet_cycles = 0;
  logic signed [31:0] cur_cen [3];

  always #4 clk_i = ~clk_i;

  ray_cylinder_intersect uut (.*);

  ray_cylinder_checker chk (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_stall_i(in_stall_o),
    .origin_x_i, .origin_y_i, .origin_z_i, .dir_x_i, .dir_y_i, .dir_z_i,
    .out_valid_i(out_valid_o), .out_stall_i,
    .hit_i(hit_o), .distance_i(distance_o),
    .point_x_i(point_x_o), .point_y_i(point_y_o), .point_z_i(point_z_o),
    .surf_normal_x_i(surf_normal_x_o), .surf_normal_y_i(surf_normal_y_o),
    .surf_normal_z_i(surf_normal_z_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // Receiver: random stalls, or one long hold on request
  always @(posedge clk_i) begin
    if (hold_req) begin
      out_stall_i <= 1'b1;
      repeat (400) @(posedge clk_i);
      hold_req = 1'b0;
    end else begin
      out_stall_i <= !calm && ($urandom_range(99) < 17);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= 20000) begin
      $display("ray_cylinder_intersect regression: fail");
      $finish;
    end
  end

  task automatic send_ray(logic signed [31:0] ox, logic signed [31:0] oy,
                          logic signed [31:0] oz, logic signed [17:0] dx,
                          logic signed [17:0] dy, logic signed [17:0] dz);
    logic taken;
    if (!calm && $urandom_range(99) < 20) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    origin_x_i <= ox;
    origin_y_i <= oy;
    origin_z_i <= oz;
    dir_x_i <= dx;
    dir_y_i <= dy;
    dir_z_i <= dz;
    do begin
      @(negedge clk_i);
      taken = !in_stall_o;
      @(posedge clk_i);
    end while (!taken);
  endtask

  task automatic drain;
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (90) @(posedge clk_i);
  endtask

  task automatic write_regs(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                            logic [17:0] axx, logic [17:0] axy, logic [17:0] axz,
                            logic [30:0] r, logic [30:0] h);
    logic [31:0] vals [8];
    vals = '{cx, cy, cz, {14'd0, axx}, {14'd0, axy}, {14'd0, axz}, {1'b0, r}, {1'b0, h}};
    cur_cen = '{cx, cy, cz};
    for (int i = 0; i < NUM_REGS; i++) begin
      cfg_we_i <= 1'b1;
      cfg_idx_i <= 3'(i);
      cfg_data_i <= vals[i];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic signed [17:0] rand_dir();
    return 18'($signed($urandom_range(92682)) - 46341);
  endfunction

  function automatic logic signed [31:0] rand_full();
    return $urandom;
  endfunction

  // Mostly rays starting near the cylinder; a fifth is unconstrained noise
  task automatic random_rays(int n);
    logic signed [31:0] o [3];
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(99) < 20) begin
        send_ray(rand_full(), rand_full(), rand_full(), 18'($urandom_range(131072) - 65536),
                 18'($urandom_range(131072) - 65536), 18'($urandom_range(131072) - 65536));
      end else begin
        for (int i = 0; i < 3; i++)
          o[i] = cur_cen[i] + $signed($urandom_range(524288)) - 262144;
        send_ray(o[0], o[1], o[2], rand_dir(), rand_dir(), rand_dir());
      end
    end
  endtask

  initial begin
    cur_cen = '{0, 0, 0};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed, reset registers: unit radius and height around the z axis
    send_ray(32'sh00020000, 0, 32'sh00008000, -18'sd65536, 0, 0);
    send_ray(0, 32'sh00030000, 32'sh00008000, 0, -18'sd65536, 0);
    send_ray(0, 0, 32'sh00008000, 18'sd65536, 0, 0);
    send_ray(0, 0, 0, 0, 0, 18'sd65536);
    send_ray(32'sh00020000, 0, 32'sh00008000, 0, 0, 18'sd65536);
    send_ray(32'sh00020000, 32'sh00020000, 0, -18'sd65536, 0, 0);
    send_ray(32'sh00020000, 0, 32'sh00030000, -18'sd65536, 0, 0);
    send_ray(32'sh00020000, 0, 32'sh00008000, 18'sd65536, 0, 0);
    send_ray(32'sh00010000, 0, 32'sh00008000, -18'sd65536, 0, 0);
    send_ray(32'sh00020000, 0, 32'sh00008000, -18'sd46341, 0, 18'sd46341);
    send_ray(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, -18'sd65536, -18'sd65536, 0);
    send_ray(32'sh80000000, 32'sh80000000, 32'sh80000000, 18'sd65536, 18'sd65536, 0);
    send_ray(32'sh7fffffff, 32'sh80000000, 0, 18'sh1ffff, 18'sh20000, 18'sh0ffff);
    send_ray(32'sh80000000, 32'sh7fffffff, 0, 18'sh20000, 18'sh1ffff, 18'sh10000);
    send_ray(32'sh00000010, 0, 32'sh00008000, 18'sd65536, 0, 0);
    send_ray(-32'sh00020000, 32'sh00010000, 32'sh00004000, 18'sd65536, 0, 0);
    drain();

    write_regs(0, 0, 0, 0, 0, 18'd65536, 31'h20000, 31'h40000);
    random_rays(300);
    drain();

    // Fill the pipeline while the receiver holds off
    write_regs(32'h00010000, 32'hfffe0000, 0, 18'h30000, 0, 0, 31'h10000, 31'h7fffffff);
    hold_req = 1'b1;
    random_rays(300);
    drain();

    calm = 1'b1;
    write_regs(32'h00008000, 0, 32'hffff0000, 18'd46341, 18'd46341, 0, 31'h18000, 31'h30000);
    random_rays(300);
    calm = 1'b0;
    drain();

    write_regs(32'h7fffffff, 32'h80000000, 32'h7fffffff, 18'h30000, 18'h10000, 18'h30000,
               31'h7fffffff, 31'h0);
    random_rays(200);
    drain();

    write_regs(32'h80000000, 32'h7fffffff, 32'h80000000, 18'h10000, 18'h30000, 18'h10000,
               31'h0, 31'h7fffffff);
    random_rays(150);
    drain();

    write_regs(32'hfff00000, 32'h00100000, 32'h00040000, 0, 0, 18'h30000, 31'h28000,
               31'h50000);
    random_rays(600);
    drain();

    if (fail_count == 0) begin
      $display("ray_cylinder_intersect regression: pass");
    end else begin
      $display("ray_cylinder_intersect regression: fail");
    end
    $finish;
  end

endmodule

@@ ray_cylinder_intersect.f @@
src/rci_pkg.sv
src/rci_front.sv
src/rci_sqrt.sv
src/rci_div.sv
src/rci_back.sv
src/ray_cylinder_intersect.sv
tb/ray_cylinder_checker.sv
tb/tb.sv
